[rtl/ffra_pkg.sv]
package ffra_pkg;

    localparam int MAX_BLOCKS_DEF = 16;
    localparam int ADDR_W         = 64;
    localparam int OWNER_W        = 8;
    localparam int CFG_INDEX_W    = 2;

    // Register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_BASE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TOTAL = 2'd1;

    typedef enum logic [1:0] {
        FUNC_ALLOC = 2'd0,
        FUNC_CHECK = 2'd1,
        FUNC_FREE  = 2'd2,
        FUNC_NOP   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOFIT    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    typedef enum logic {
        UOP_ADD = 1'b0,
        UOP_SUB = 1'b1
    } unit_op_t;

    typedef struct packed {
        logic carry;
        logic eq;
    } unit_flags_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  start;
        logic [ADDR_W-1:0]  size;
        logic               taken;
        logic [OWNER_W-1:0] owner;
    } region_t;

endpackage

[rtl/ffra_unit.sv]
// Shared 64-bit adder/subtractor with a result compare.
module ffra_unit (
    input  ffra_pkg::unit_op_t            op,
    input  logic [ffra_pkg::ADDR_W-1:0]   a,
    input  logic [ffra_pkg::ADDR_W-1:0]   b,
    input  logic [ffra_pkg::ADDR_W-1:0]   c,
    output logic [ffra_pkg::ADDR_W-1:0]   result,
    output ffra_pkg::unit_flags_t         flags
);

    logic [ffra_pkg::ADDR_W:0]   sum;
    logic [ffra_pkg::ADDR_W-1:0] b_op;

    // Subtract as a + ~b + 1; carry out set means a >= b
    assign b_op = (op == ffra_pkg::UOP_SUB) ? ~b : b;
    assign sum  = {1'b0, a} + {1'b0, b_op}
                + {{ffra_pkg::ADDR_W{1'b0}}, (op == ffra_pkg::UOP_SUB)};

    assign result      = sum[ffra_pkg::ADDR_W-1:0];
    assign flags.carry = sum[ffra_pkg::ADDR_W];
    assign flags.eq    = (sum[ffra_pkg::ADDR_W-1:0] == c);

endmodule

[rtl/ffra_table.sv]
// Region table: one write port, one registered read port.
module ffra_table #(
    parameter int DEPTH = ffra_pkg::MAX_BLOCKS_DEF,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [IDX_W-1:0]     waddr,
    input  ffra_pkg::region_t    wdata,
    input  logic [IDX_W-1:0]     raddr,
    output ffra_pkg::region_t    rdata
);

    ffra_pkg::region_t mem_reg [DEPTH];
    ffra_pkg::region_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/first_fit_region_allocator.sv]
// Channel   Handshake                 Payload
// --------  ------------------------  ------------------------------------------------
// command   start / busy              func, owner_type, request_size, release_address
// result    done (one-cycle strobe)   status, granted_address
// config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One command word is taken at an edge with start high and busy low; busy then
// stays high until the result is issued, but a no-op answers at once and never
// raises busy. The table lives in a memory with one write port and one registered
// read port; each scanned entry takes a read and an evaluate step, and each entry
// moved by a split or a merge takes a read and a write step. The result strobe is
// registered from the last step, and busy drops in the cycle the strobe rises.
// Reset clears control state at once; no clearing pass is run: entry 0 reads back
// the configured window until it is first written, and later entries are only read
// below the region count. The receiver cannot stall; done is high for one cycle.
module first_fit_region_allocator #(
    parameter int MAX_BLOCKS = ffra_pkg::MAX_BLOCKS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // command
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          func,
    input  logic [ffra_pkg::OWNER_W-1:0]        owner_type,
    input  logic [ffra_pkg::ADDR_W-1:0]         request_size,
    input  logic [ffra_pkg::ADDR_W-1:0]         release_address,
    // result
    output logic                                done,
    output logic [1:0]                          status,
    output logic [ffra_pkg::ADDR_W-1:0]         granted_address,
    // config
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ffra_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ffra_pkg::ADDR_W-1:0]         cfg_data
);

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_BLOCKS);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    typedef enum logic [16:0] {
        S_IDLE    = 17'h00001,
        S_SCAN_RD = 17'h00002,
        S_SCAN_EV = 17'h00004,
        S_INS_RD  = 17'h00008,
        S_INS_WR  = 17'h00010,
        S_INS_NEW = 17'h00020,
        S_WR_POS  = 17'h00040,
        S_NXT_RD  = 17'h00080,
        S_NXT_EV  = 17'h00100,
        S_NXT_SUM = 17'h00200,
        S_REM_RD  = 17'h00400,
        S_REM_WR  = 17'h00800,
        S_CUR_WR  = 17'h01000,
        S_PRV_RD  = 17'h02000,
        S_PRV_EV  = 17'h04000,
        S_PRV_SUM = 17'h08000,
        S_SPARE   = 17'h10000
    } state_t;

    // Control state
    state_t                      state_reg, state_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic                        fresh_reg, fresh_next;
    logic                        fresh_hit_reg, fresh_hit_next;
    logic [ffra_pkg::ADDR_W-1:0] base_reg, base_next;
    logic [ffra_pkg::ADDR_W-1:0] total_reg, total_next;
    logic                        done_reg, done_next;

    // Working payload
    ffra_pkg::func_t             func_reg, func_next;
    logic [ffra_pkg::OWNER_W-1:0] owner_reg, owner_next;
    logic [ffra_pkg::ADDR_W-1:0] req_reg, req_next;
    logic [ffra_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic [IDX_W-1:0]            k_reg, k_next;
    logic [IDX_W-1:0]            pos_reg, pos_next;
    ffra_pkg::region_t           cur_reg, cur_next;
    ffra_pkg::region_t           nb_reg, nb_next;
    logic [ffra_pkg::ADDR_W-1:0] diff_reg, diff_next;
    logic                        split_reg, split_next;
    logic                        rem_ret_reg, rem_ret_next;
    ffra_pkg::status_t           status_reg, status_next;
    logic [ffra_pkg::ADDR_W-1:0] granted_reg, granted_next;

    // Table port
    logic                        tbl_we;
    logic [IDX_W-1:0]            tbl_waddr;
    ffra_pkg::region_t           tbl_wdata;
    logic [IDX_W-1:0]            tbl_raddr;
    ffra_pkg::region_t           tbl_rdata;
    ffra_pkg::region_t           rd;

    // Shared unit
    ffra_pkg::unit_op_t          u_op;
    logic [ffra_pkg::ADDR_W-1:0] u_a, u_b, u_c, u_res;
    ffra_pkg::unit_flags_t       u_flags;

    logic [CNT_W-1:0]            k_ext, pos_ext, cnt_m1;
    logic                        scan_hit, scan_last, scan_split, cfg_hit;

    ffra_table #(
        .DEPTH (MAX_BLOCKS),
        .IDX_W (IDX_W)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    ffra_unit u_unit (
        .op     (u_op),
        .a      (u_a),
        .b      (u_b),
        .c      (u_c),
        .result (u_res),
        .flags  (u_flags)
    );

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = !busy;
    assign done            = done_reg;
    assign status          = status_reg;
    assign granted_address = granted_reg;

    // Entry 0 shows the configured window until the sequencer first writes it
    always_comb
    begin
        if (fresh_hit_reg)
        begin
            rd = '{start: base_reg, size: total_reg, taken: 1'b0, owner: '0};
        end
        else
        begin
            rd = tbl_rdata;
        end
    end

    assign k_ext   = CNT_W'(k_reg);
    assign pos_ext = CNT_W'(pos_reg);
    assign cnt_m1  = count_reg - CNT_ONE;
    assign cfg_hit = cfg_valid && cfg_ready
                   && (cfg_index == ffra_pkg::REG_BASE || cfg_index == ffra_pkg::REG_TOTAL);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        fresh_next   = fresh_reg;
        base_next    = base_reg;
        total_next   = total_reg;
        done_next    = 1'b0;
        func_next    = func_reg;
        owner_next   = owner_reg;
        req_next     = req_reg;
        addr_next    = addr_reg;
        k_next       = k_reg;
        pos_next     = pos_reg;
        cur_next     = cur_reg;
        nb_next      = nb_reg;
        diff_next    = diff_reg;
        split_next   = split_reg;
        rem_ret_next = rem_ret_reg;
        status_next  = status_reg;
        granted_next = granted_reg;

        tbl_we    = 1'b0;
        tbl_waddr = pos_reg;
        tbl_wdata = cur_reg;
        tbl_raddr = k_reg;

        u_op = ffra_pkg::UOP_ADD;
        u_a  = '0;
        u_b  = '0;
        u_c  = '0;

        scan_hit   = 1'b0;
        scan_last  = (k_ext + CNT_ONE == count_reg);
        scan_split = u_flags.carry && !u_flags.eq;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    func_next  = ffra_pkg::func_t'(func);
                    owner_next = owner_type;
                    req_next   = request_size;
                    addr_next  = release_address;
                    k_next     = '0;
                    if (ffra_pkg::func_t'(func) == ffra_pkg::FUNC_NOP)
                    begin
                        // no-op: answer at once, table untouched
                        done_next    = 1'b1;
                        status_next  = ffra_pkg::ST_OK;
                        granted_next = '0;
                    end
                    else
                    begin
                        state_next = S_SCAN_RD;
                    end
                end
            end

            S_SCAN_RD:
            begin
                tbl_raddr  = k_reg;
                state_next = S_SCAN_EV;
            end

            S_SCAN_EV:
            begin
                u_op = ffra_pkg::UOP_SUB;
                if (func_reg == ffra_pkg::FUNC_FREE)
                begin
                    u_a      = rd.start;
                    u_b      = addr_reg;
                    scan_hit = rd.taken && u_flags.eq;
                end
                else
                begin
                    u_a      = rd.size;
                    u_b      = req_reg;
                    scan_hit = !rd.taken && u_flags.carry;
                end

                if (scan_hit)
                begin
                    pos_next = k_reg;
                    cur_next = rd;
                    unique case (func_reg)
                        ffra_pkg::FUNC_CHECK:
                        begin
                            done_next    = 1'b1;
                            status_next  = (scan_split && count_reg == CNT_MAX)
                                         ? ffra_pkg::ST_FULL : ffra_pkg::ST_OK;
                            granted_next = '0;
                            state_next   = S_IDLE;
                        end
                        ffra_pkg::FUNC_ALLOC:
                        begin
                            diff_next  = u_res;
                            split_next = scan_split;
                            if (scan_split && count_reg == CNT_MAX)
                            begin
                                done_next    = 1'b1;
                                status_next  = ffra_pkg::ST_FULL;
                                granted_next = '0;
                                state_next   = S_IDLE;
                            end
                            else if (scan_split)
                            begin
                                // open a slot after the chosen entry
                                k_next = cnt_m1[IDX_W-1:0];
                                if (cnt_m1 > k_ext)
                                begin
                                    state_next = S_INS_RD;
                                end
                                else
                                begin
                                    state_next = S_INS_NEW;
                                end
                            end
                            else
                            begin
                                state_next = S_WR_POS;
                            end
                        end
                        ffra_pkg::FUNC_FREE:
                        begin
                            state_next = scan_last ? S_CUR_WR : S_NXT_RD;
                        end
                        ffra_pkg::FUNC_NOP:
                        begin
                            done_next    = 1'b1;
                            status_next  = ffra_pkg::ST_OK;
                            granted_next = '0;
                            state_next   = S_IDLE;
                        end
                    endcase
                end
                else if (scan_last)
                begin
                    done_next    = 1'b1;
                    status_next  = (func_reg == ffra_pkg::FUNC_FREE)
                                 ? ffra_pkg::ST_NOTFOUND : ffra_pkg::ST_NOFIT;
                    granted_next = '0;
                    state_next   = S_IDLE;
                end
                else
                begin
                    k_next     = k_reg + IDX_W'(1);
                    state_next = S_SCAN_RD;
                end
            end

            S_INS_RD:
            begin
                tbl_raddr  = k_reg;
                state_next = S_INS_WR;
            end

            S_INS_WR:
            begin
                tbl_we    = 1'b1;
                tbl_waddr = k_reg + IDX_W'(1);
                tbl_wdata = rd;
                k_next    = k_reg - IDX_W'(1);
                if (k_ext > pos_ext + CNT_ONE)
                begin
                    state_next = S_INS_RD;
                end
                else
                begin
                    state_next = S_INS_NEW;
                end
            end

            S_INS_NEW:
            begin
                // remainder becomes a free entry just after the grant
                u_op      = ffra_pkg::UOP_ADD;
                u_a       = cur_reg.start;
                u_b       = req_reg;
                tbl_we    = 1'b1;
                tbl_waddr = pos_reg + IDX_W'(1);
                tbl_wdata = '{start: u_res, size: diff_reg, taken: 1'b0, owner: '0};
                state_next = S_WR_POS;
            end

            S_WR_POS:
            begin
                tbl_we    = 1'b1;
                tbl_waddr = pos_reg;
                tbl_wdata = '{start: cur_reg.start, size: req_reg, taken: 1'b1,
                              owner: owner_reg};
                if (split_reg)
                begin
                    count_next = count_reg + CNT_ONE;
                end
                done_next    = 1'b1;
                status_next  = ffra_pkg::ST_OK;
                granted_next = cur_reg.start;
                state_next   = S_IDLE;
            end

            S_NXT_RD:
            begin
                tbl_raddr  = pos_reg + IDX_W'(1);
                state_next = S_NXT_EV;
            end

            S_NXT_EV:
            begin
                u_op    = ffra_pkg::UOP_ADD;
                u_a     = cur_reg.start;
                u_b     = cur_reg.size;
                u_c     = rd.start;
                nb_next = rd;
                state_next = (!rd.taken && u_flags.eq) ? S_NXT_SUM : S_CUR_WR;
            end

            S_NXT_SUM:
            begin
                u_op          = ffra_pkg::UOP_ADD;
                u_a           = cur_reg.size;
                u_b           = nb_reg.size;
                cur_next.size = u_res;
                k_next        = pos_reg + IDX_W'(1);
                rem_ret_next  = 1'b0;
                state_next    = S_REM_RD;
            end

            S_REM_RD:
            begin
                if (k_ext + CNT_ONE < count_reg)
                begin
                    tbl_raddr  = k_reg + IDX_W'(1);
                    state_next = S_REM_WR;
                end
                else
                begin
                    count_next = cnt_m1;
                    if (rem_ret_reg)
                    begin
                        done_next    = 1'b1;
                        status_next  = ffra_pkg::ST_OK;
                        granted_next = '0;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_CUR_WR;
                    end
                end
            end

            S_REM_WR:
            begin
                tbl_we     = 1'b1;
                tbl_waddr  = k_reg;
                tbl_wdata  = rd;
                k_next     = k_reg + IDX_W'(1);
                state_next = S_REM_RD;
            end

            S_CUR_WR:
            begin
                tbl_we    = 1'b1;
                tbl_waddr = pos_reg;
                tbl_wdata = '{start: cur_reg.start, size: cur_reg.size, taken: 1'b0,
                              owner: cur_reg.owner};
                cur_next.taken = 1'b0;
                if (pos_reg != '0)
                begin
                    state_next = S_PRV_RD;
                end
                else
                begin
                    done_next    = 1'b1;
                    status_next  = ffra_pkg::ST_OK;
                    granted_next = '0;
                    state_next   = S_IDLE;
                end
            end

            S_PRV_RD:
            begin
                tbl_raddr  = pos_reg - IDX_W'(1);
                state_next = S_PRV_EV;
            end

            S_PRV_EV:
            begin
                u_op    = ffra_pkg::UOP_ADD;
                u_a     = rd.start;
                u_b     = rd.size;
                u_c     = cur_reg.start;
                nb_next = rd;
                if (!rd.taken && u_flags.eq)
                begin
                    state_next = S_PRV_SUM;
                end
                else
                begin
                    done_next    = 1'b1;
                    status_next  = ffra_pkg::ST_OK;
                    granted_next = '0;
                    state_next   = S_IDLE;
                end
            end

            S_PRV_SUM:
            begin
                // grow the previous entry, then drop the freed one
                u_op      = ffra_pkg::UOP_ADD;
                u_a       = nb_reg.size;
                u_b       = cur_reg.size;
                tbl_we    = 1'b1;
                tbl_waddr = pos_reg - IDX_W'(1);
                tbl_wdata = '{start: nb_reg.start, size: u_res, taken: nb_reg.taken,
                              owner: nb_reg.owner};
                k_next       = pos_reg;
                rem_ret_next = 1'b1;
                state_next   = S_REM_RD;
            end

            S_SPARE:
            begin
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // first write of entry 0 hands it over to the memory
        if (tbl_we && tbl_waddr == '0)
        begin
            fresh_next = 1'b0;
        end

        // base or total write: latch the register and drop the table back to one region
        if (cfg_valid && cfg_ready)
        begin
            priority if (cfg_index == ffra_pkg::REG_BASE)
            begin
                base_next  = cfg_data;
                count_next = CNT_ONE;
                fresh_next = 1'b1;
            end
            else if (cfg_index == ffra_pkg::REG_TOTAL)
            begin
                total_next = cfg_data;
                count_next = CNT_ONE;
                fresh_next = 1'b1;
            end
            else
            begin
                count_next = count_next;
            end
        end

        fresh_hit_next = fresh_reg && (tbl_raddr == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= CNT_ONE;
            fresh_reg     <= 1'b1;
            fresh_hit_reg <= 1'b0;
            base_reg      <= '0;
            total_reg     <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            fresh_reg     <= fresh_next;
            fresh_hit_reg <= fresh_hit_next;
            base_reg      <= base_next;
            total_reg     <= total_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        owner_reg   <= owner_next;
        req_reg     <= req_next;
        addr_reg    <= addr_next;
        k_reg       <= k_next;
        pos_reg     <= pos_next;
        cur_reg     <= cur_next;
        nb_reg      <= nb_next;
        diff_reg    <= diff_next;
        split_reg   <= split_next;
        rem_ret_reg <= rem_ret_next;
        status_reg  <= status_next;
        granted_reg <= granted_next;
    end

    // The table never empties and never overflows
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != '0) && (count_reg <= CNT_MAX))
        else $error("region count out of range");

    // Table-full verdict only when the table was really full
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && status_reg == ffra_pkg::ST_FULL) |-> ($past(count_reg) == CNT_MAX))
        else $error("table-full status with room left");

    // A nonzero grant only comes with a good status
    a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && granted_reg != '0) |-> (status_reg == ffra_pkg::ST_OK))
        else $error("grant issued with failing status");

    // A base or total register write leaves exactly one region, taken from the window
    a_cfg_init: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_hit |=> (count_reg == CNT_ONE && fresh_reg))
        else $error("table not reinitialized after register write");

endmodule

[verif/ffra_tb_pkg.sv]
package ffra_tb_pkg;

    import ffra_pkg::*;

    localparam int TBL_DEPTH = MAX_BLOCKS_DEF;

    typedef struct packed {
        status_t           status;
        logic [ADDR_W-1:0] granted;
    } reply_t;

    // Mirror of the region table plus the replies it predicts, oldest first.
    class region_ledger;

        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] span;
        region_t           tbl [TBL_DEPTH];
        int unsigned       used;
        reply_t            pending [$];
        int unsigned       mismatches;
        int unsigned       replies_seen;
        int unsigned       cfg_writes;
        int unsigned       per_func [4];
        int unsigned       per_status [4];

        function new();
            base = '0;
            span = '0;
            mismatches = 0;
            replies_seen = 0;
            cfg_writes = 0;
            for (int k = 0; k < 4; k++)
            begin
                per_func[k] = 0;
                per_status[k] = 0;
            end
            clear_table();
        endfunction

        function void clear_table();
            for (int k = 0; k < TBL_DEPTH; k++)
                tbl[k] = '0;
            tbl[0].start = base;
            tbl[0].size = span;
            used = 1;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [ADDR_W-1:0] data);
            cfg_writes++;
            if (idx == REG_BASE)
                base = data;
            else if (idx == REG_TOTAL)
                span = data;
            else
                return;
            clear_table();
        endfunction

        function status_t find_first_fit(logic [ADDR_W-1:0] req, output int unsigned pos);
            pos = 0;
            for (int unsigned k = 0; k < used; k++)
            begin
                if (!tbl[k].taken && tbl[k].size >= req)
                begin
                    pos = k;
                    if (tbl[k].size > req && used >= TBL_DEPTH)
                        return ST_FULL;
                    return ST_OK;
                end
            end
            return ST_NOFIT;
        endfunction

        // Remove an entry, close the gap and clear the vacated last slot.
        function void drop_entry(int unsigned pos);
            for (int unsigned k = pos; k + 1 < used; k++)
                tbl[k] = tbl[k + 1];
            used--;
            tbl[used] = '0;
        endfunction

        function void log_command(func_t f, logic [OWNER_W-1:0] tag,
                                  logic [ADDR_W-1:0] req, logic [ADDR_W-1:0] addr);
            reply_t      r;
            int unsigned pos;
            bit          hit;
            r.status = ST_OK;
            r.granted = '0;
            hit = 0;
            per_func[int'(f)]++;
            case (f)
                FUNC_ALLOC:
                begin
                    r.status = find_first_fit(req, pos);
                    if (r.status == ST_OK)
                    begin
                        r.granted = tbl[pos].start;
                        if (tbl[pos].size > req)
                        begin
                            for (int unsigned k = used; k > pos + 1; k--)
                                tbl[k] = tbl[k - 1];
                            tbl[pos + 1].start = tbl[pos].start + req;
                            tbl[pos + 1].size  = tbl[pos].size - req;
                            tbl[pos + 1].taken = 1'b0;
                            tbl[pos + 1].owner = '0;
                            used++;
                        end
                        tbl[pos].size  = req;
                        tbl[pos].taken = 1'b1;
                        tbl[pos].owner = tag;
                    end
                end
                FUNC_CHECK:
                    r.status = find_first_fit(req, pos);
                FUNC_FREE:
                begin
                    pos = 0;
                    for (int unsigned k = 0; k < used && !hit; k++)
                    begin
                        if (tbl[k].taken && tbl[k].start == addr)
                        begin
                            pos = k;
                            hit = 1;
                        end
                    end
                    if (!hit)
                        r.status = ST_NOTFOUND;
                    else
                    begin
                        tbl[pos].taken = 1'b0;
                        if (pos + 1 < used && !tbl[pos + 1].taken &&
                            tbl[pos].start + tbl[pos].size == tbl[pos + 1].start)
                        begin
                            tbl[pos].size = tbl[pos].size + tbl[pos + 1].size;
                            drop_entry(pos + 1);
                        end
                        if (pos > 0 && !tbl[pos - 1].taken &&
                            tbl[pos - 1].start + tbl[pos - 1].size == tbl[pos].start)
                        begin
                            tbl[pos - 1].size = tbl[pos - 1].size + tbl[pos].size;
                            drop_entry(pos);
                        end
                    end
                end
                default:
                    ;
            endcase
            per_status[int'(r.status)]++;
            pending.push_back(r);
        endfunction

        function void note_fail(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%s", msg);
        endfunction

        function void check_reply(logic [1:0] st, logic [ADDR_W-1:0] ga);
            reply_t want;
            replies_seen++;
            if (pending.size() == 0)
            begin
                note_fail($sformatf("unexpected result: status %0d granted %h", st, ga));
                return;
            end
            want = pending.pop_front();
            if (st !== want.status || ga !== want.granted)
                note_fail($sformatf("result %0d: status %0d (want %0d), granted %h (want %h)",
                                    replies_seen, st, want.status, ga, want.granted));
        endfunction

        function void pick_taken_start(output bit ok, output logic [ADDR_W-1:0] addr);
            int unsigned hits [$];
            ok = 0;
            addr = '0;
            for (int unsigned k = 0; k < used; k++)
                if (tbl[k].taken)
                    hits.push_back(k);
            if (hits.size() == 0)
                return;
            ok = 1;
            addr = tbl[hits[$urandom_range(0, hits.size() - 1)]].start;
        endfunction

        function void pick_free_size(output bit ok, output logic [ADDR_W-1:0] sz);
            int unsigned hits [$];
            ok = 0;
            sz = '0;
            for (int unsigned k = 0; k < used; k++)
                if (!tbl[k].taken)
                    hits.push_back(k);
            if (hits.size() == 0)
                return;
            ok = 1;
            sz = tbl[hits[$urandom_range(0, hits.size() - 1)]].size;
        endfunction

    endclass

endpackage

[verif/tb_first_fit_region_allocator.sv]
module tb_first_fit_region_allocator;

    timeunit 1ns;
    timeprecision 1ps;

    import ffra_pkg::*;
    import ffra_tb_pkg::*;

    // Indexes the block decodes to nothing; writes there must leave the table alone
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_B = 2'd3;

    localparam int PHASES         = 6;
    localparam int ITEMS_PER_PHASE = 250;
    // Worst case is the longest command plus the longest gap for every word of the
    // whole run; allow several times that.
    localparam int CYCLE_LIMIT    = 1_000_000;

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [1:0]               func;
    logic [OWNER_W-1:0]       owner_type;
    logic [ADDR_W-1:0]        request_size;
    logic [ADDR_W-1:0]        release_address;
    logic                     done;
    logic [1:0]               status;
    logic [ADDR_W-1:0]        granted_address;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_INDEX_W-1:0]   cfg_index;
    logic [ADDR_W-1:0]        cfg_data;

    region_ledger ledger = new();

    int unsigned cycle_count = 0;
    int unsigned calm_left = 0;
    int unsigned windows = 0;

    first_fit_region_allocator #(
        .MAX_BLOCKS(MAX_BLOCKS_DEF)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .func(func),
        .owner_type(owner_type),
        .request_size(request_size),
        .release_address(release_address),
        .done(done),
        .status(status),
        .granted_address(granted_address),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // Watchdog: a hung handshake must not hang the run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_count, ledger.pending.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result monitor: done is a one-cycle strobe, so every high sample is a word
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
            ledger.check_reply(status, granted_address);
    end

    function automatic logic [ADDR_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Mostly back-to-back or short gaps, a few long ones, and now and then a
    // stretch of words with no gap at all.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Request sizes: mostly a fraction of the window so the table fills and
    // splits, some exact fits against a free entry, some zero, some anything.
    function automatic logic [ADDR_W-1:0] pick_size();
        logic [ADDR_W-1:0] lim;
        logic [ADDR_W-1:0] sz;
        bit                ok;
        int unsigned       r;
        r = $urandom_range(0, 99);
        if (r < 6)
            return '0;
        if (r < 12)
            return rand64();
        if (r < 32)
        begin
            ledger.pick_free_size(ok, sz);
            if (ok)
                return sz;
        end
        lim = ledger.span >> $urandom_range(2, 5);
        if (lim == '0)
            return ADDR_W'($urandom_range(0, 3));
        return rand64() % lim + 1;
    endfunction

    // Present one command word, hold it until the block takes it, then log it
    task automatic issue(input func_t f, input logic [OWNER_W-1:0] tag,
                         input logic [ADDR_W-1:0] req, input logic [ADDR_W-1:0] addr);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start = 1'b1;
        func = f;
        owner_type = tag;
        request_size = req;
        release_address = addr;
        do @(posedge clk); while (busy !== 1'b0);
        ledger.log_command(f, tag, req, addr);
    endtask

    // Drop start and wait until every predicted result has come back
    task automatic settle();
        @(negedge clk);
        start = 1'b0;
        while (ledger.pending.size() != 0)
            @(posedge clk);
    endtask

    // Register writes go in only while the block is idle
    task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [ADDR_W-1:0] data);
        settle();
        repeat (pick_gap()) @(negedge clk);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        ledger.write_reg(idx, data);
        // lower valid before the next edge so the word is taken once
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_window(input logic [ADDR_W-1:0] b, input logic [ADDR_W-1:0] s);
        if ($urandom_range(0, 3) == 0)
            write_cfg($urandom_range(0, 1) ? REG_UNUSED_A : REG_UNUSED_B, rand64());
        if ($urandom_range(0, 1))
        begin
            write_cfg(REG_BASE, b);
            write_cfg(REG_TOTAL, s);
        end
        else
        begin
            write_cfg(REG_TOTAL, s);
            write_cfg(REG_BASE, b);
        end
        windows++;
    endtask

    // Random traffic: allocs and frees of live blocks dominate so the table
    // runs through splits, merges and the full condition; the rest is checks,
    // frees of bogus addresses and the unused function code.
    task automatic run_random(input int unsigned n);
        logic [ADDR_W-1:0] addr;
        bit                ok;
        int unsigned       r;
        for (int unsigned i = 0; i < n; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                issue(FUNC_ALLOC, OWNER_W'($urandom), pick_size(), rand64());
            else if (r < 60)
                issue(FUNC_CHECK, OWNER_W'($urandom), pick_size(), rand64());
            else if (r < 88)
            begin
                ledger.pick_taken_start(ok, addr);
                if (!ok)
                    addr = rand64();
                issue(FUNC_FREE, OWNER_W'($urandom), rand64(), addr);
            end
            else if (r < 95)
            begin
                ledger.pick_taken_start(ok, addr);
                addr = ($urandom_range(0, 1) || !ok) ? rand64() : addr + 1;
                issue(FUNC_FREE, OWNER_W'($urandom), rand64(), addr);
            end
            else
                issue(FUNC_NOP, OWNER_W'($urandom), rand64(), rand64());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        func = FUNC_ALLOC;
        owner_type = '0;
        request_size = '0;
        release_address = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_BASE;
        cfg_data = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset window: base 0, size 0. Only a zero request can fit.
        issue(FUNC_ALLOC, 8'h5A, 64'd1, '1);
        issue(FUNC_ALLOC, 8'hFF, 64'd0, 64'd0);
        issue(FUNC_FREE, 8'h00, '1, 64'd0);
        issue(FUNC_NOP, 8'hFF, '1, '1);

        // Unused indexes first, then a small window: split, zero-size block on
        // a shared start, free of that shared start, merges with the next entry.
        write_cfg(REG_UNUSED_A, '1);
        write_cfg(REG_UNUSED_B, rand64());
        write_cfg(REG_BASE, 64'h1000);
        write_cfg(REG_TOTAL, 64'h100);
        issue(FUNC_ALLOC, 8'hFF, 64'h10, '0);
        issue(FUNC_ALLOC, 8'h00, 64'h0, '1);
        issue(FUNC_CHECK, 8'h3C, '1, '0);
        issue(FUNC_FREE, 8'h00, '0, 64'h1234);
        issue(FUNC_FREE, 8'h00, '0, 64'h1010);
        issue(FUNC_FREE, 8'h00, '0, 64'h1000);

        // Window that wraps past the top of the address space; fill the table
        // so a split is refused, then take the remainder as an exact fit.
        write_cfg(REG_BASE, 64'hFFFF_FFFF_FFFF_FFF0);
        write_cfg(REG_TOTAL, 64'h20);
        for (int i = 0; i < MAX_BLOCKS_DEF - 1; i++)
            issue(FUNC_ALLOC, OWNER_W'(i), 64'd1, '0);
        issue(FUNC_ALLOC, 8'h11, 64'd1, '0);
        issue(FUNC_CHECK, 8'h22, 64'd1, '0);
        issue(FUNC_ALLOC, 8'h33, 64'h11, '0);
        windows = 3;

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: set_window('0, 64'h400);
                1: set_window(rand64(), ADDR_W'($urandom_range(64, 4096)));
                2: set_window(64'hFFFF_FFFF_FFFF_FF00, 64'h200);
                3: set_window('1, '1);
                4: set_window('0, '0);
                default: set_window(rand64(), rand64());
            endcase
            run_random(ITEMS_PER_PHASE);
        end

        // Drain, then give the block a few more cycles to show any stray strobe
        settle();
        repeat (16) @(posedge clk);

        $display("%0d commands (alloc %0d, check %0d, free %0d, unused code %0d) over %0d windows,"
                 , ledger.per_func[0] + ledger.per_func[1] + ledger.per_func[2]
                 + ledger.per_func[3], ledger.per_func[0], ledger.per_func[1],
                 ledger.per_func[2], ledger.per_func[3], windows);
        $display("%0d register writes; outcomes ok %0d, no fit %0d, full %0d, not found %0d",
                 ledger.cfg_writes, ledger.per_status[0], ledger.per_status[1],
                 ledger.per_status[2], ledger.per_status[3]);
        if (ledger.pending.size() != 0)
            $display("%0d results never arrived", ledger.pending.size());

        if (ledger.mismatches == 0 && ledger.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
